FILE: sv/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared widths, codes and types of the top-k score selector.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int unsigned SCORE_W    = 11;
  localparam int unsigned STAMP_W    = 16;
  localparam int unsigned KEEP_W     = 7;
  localparam int unsigned MAPQ_W     = 8;
  localparam int unsigned MEDQ_W     = 7;
  localparam int unsigned IN_ID_W    = 32;
  localparam int unsigned OUT_ID_W   = 32;
  localparam int unsigned TOTAL_W    = 7;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 56;
  localparam int unsigned M_TUSER_W  = 2;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [SCORE_W-1:0]    TOP_SCORE  = 11'd1147;
  localparam logic [KEEP_W-1:0]     KEEP_RESET = 7'd64;

  localparam logic [CFG_ADDR_W-1:0] REG_KEEP_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_USE_MAPQ   = 1'b1;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_DECIDE  = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_REPLACE = 5'b01000,
    ST_DRAIN   = 5'b10000
  } tks_state_e;

  typedef struct packed {
    logic en;
    logic first;
    logic in_range;
  } scan_ctl_t;

endpackage

FILE: sv/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell
// One slot of the ring: holds score, id and stamp; loads from its neighbor
// on a shift or from the write bus on a write.
// ----------------------------------------------------------------------------
module tks_cell import tks_pkg::*; #(
  parameter int unsigned ID_BITS = 32
) (
  input  logic               clk_i,
  input  logic               shift_en_i,
  input  logic               wr_en_i,
  input  logic [SCORE_W-1:0] nb_score_i,
  input  logic [ID_BITS-1:0] nb_id_i,
  input  logic [STAMP_W-1:0] nb_stamp_i,
  input  logic [SCORE_W-1:0] wr_score_i,
  input  logic [ID_BITS-1:0] wr_id_i,
  input  logic [STAMP_W-1:0] wr_stamp_i,
  output logic [SCORE_W-1:0] score_o,
  output logic [ID_BITS-1:0] id_o,
  output logic [STAMP_W-1:0] stamp_o
);

  logic [SCORE_W-1:0] score_q;
  logic [ID_BITS-1:0] id_q;
  logic [STAMP_W-1:0] stamp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      score_q <= wr_score_i;
      id_q    <= wr_id_i;
      stamp_q <= wr_stamp_i;
    end else if (shift_en_i) begin
      score_q <= nb_score_i;
      id_q    <= nb_id_i;
      stamp_q <= nb_stamp_i;
    end
  end

  assign score_o = score_q;
  assign id_o    = id_q;
  assign stamp_o = stamp_q;

endmodule

FILE: sv/tks_scan.sv
// ----------------------------------------------------------------------------
// tks_scan
// Victim search at the head of the ring: one slot per cycle while enabled, finds
// the most recent entry at the lowest score, whether the lowest score repeats,
// and the smallest score above it.
// ----------------------------------------------------------------------------
module tks_scan import tks_pkg::*; #(
  parameter int unsigned MAX_KEEP = 64,
  parameter int unsigned ID_BITS  = 32,
  localparam int unsigned IDX_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scan_ctl_t          ctl_i,
  input  logic [IDX_W-1:0]   slot_i,
  input  logic [SCORE_W-1:0] score_i,
  input  logic [ID_BITS-1:0] id_i,
  input  logic [STAMP_W-1:0] stamp_i,
  input  logic [SCORE_W-1:0] lowest_i,
  input  logic [STAMP_W-1:0] ctr_i,
  output logic               found_o,
  output logic               dup_o,
  output logic [IDX_W-1:0]   best_idx_o,
  output logic [ID_BITS-1:0] best_id_o,
  output logic [SCORE_W-1:0] best_score_o,
  output logic [SCORE_W-1:0] second_o
);

  logic               found_q, found_d;
  logic               dup_q, dup_d;
  logic [SCORE_W-1:0] second_q, second_d;
  logic [IDX_W-1:0]   best_idx_q;
  logic [STAMP_W-1:0] best_age_q;
  logic [ID_BITS-1:0] best_id_q;
  logic [SCORE_W-1:0] best_score_q;

  logic               found_c, dup_c, at_low, take;
  logic [SCORE_W-1:0] sec_c;
  logic [STAMP_W-1:0] age;

  always_comb begin
    found_c  = ctl_i.first ? 1'b0 : found_q;
    dup_c    = ctl_i.first ? 1'b0 : dup_q;
    sec_c    = ctl_i.first ? TOP_SCORE : second_q;
    age      = ctr_i - stamp_i;
    at_low   = ctl_i.in_range && (score_i == lowest_i);
    take     = at_low && (!found_c || (age < best_age_q));
    found_d  = found_c | at_low;
    dup_d    = dup_c | (at_low & found_c);
    second_d = (ctl_i.in_range && !at_low && (score_i < sec_c)) ? score_i : sec_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      dup_q   <= 1'b0;
    end else if (ctl_i.en) begin
      found_q <= found_d;
      dup_q   <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      second_q <= second_d;
      if (take) begin
        best_idx_q   <= slot_i;
        best_age_q   <= age;
        best_id_q    <= id_i;
        best_score_q <= score_i;
      end
    end
  end

  assign found_o      = found_q;
  assign dup_o        = dup_q;
  assign best_idx_o   = best_idx_q;
  assign best_id_o    = best_id_q;
  assign best_score_o = best_score_q;
  assign second_o     = second_q;

endmodule

FILE: sv/top_k_score_selector_unit.sv
// ----------------------------------------------------------------------------
// top_k_score_selector_unit
// Keeps the best-scoring reads of a stream in a ring of slot cells.
// ----------------------------------------------------------------------------
// Input words (s_axis) carry either an offer (tuser = 0) or a drain (tuser = 1).
// An offer gives one output word: accepted flag, evicted id and score when an
// entry was replaced, and the kept count. A drain gives one word per kept read
// in slot order, tlast on the final one (a single empty word when nothing is
// kept), then empties the store.
// Sequence: an offer that fills a free slot or is rejected is settled in the
// decide step, which registers its result and returns to idle. An offer that
// replaces an entry passes through the scan and replace steps: the ring
// rotates once past the head comparator to find the victim. A drain emits one
// word per cycle from the rotating ring while the receiver takes them.
// Configuration (keep_count, use_mapq) is to be written through cfg_we_i while
// idle; the block does not enforce it. Reset: store empty, keep_count = 64,
// use_mapq = 0; store contents are not cleared. A new word is taken while the
// output register still holds a result; when the receiver stalls the output
// register holds and the block waits in its decide, replace or drain step.
// ----------------------------------------------------------------------------
module top_k_score_selector_unit import tks_pkg::*; #(
  parameter int unsigned MAX_KEEP = 64,
  parameter int unsigned ID_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // mapq, median_q, read_id
  input  logic                  s_axis_tuser,  // op
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // out_id, out_score, kept_total
  output logic [M_TUSER_W-1:0]  m_axis_tuser,  // accepted, id_valid
  output logic                  m_axis_tlast
);

  localparam int unsigned IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_KEEP + 1);
  localparam int unsigned KW    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_KEEP - 1);

  tks_state_e         state_q, state_d;
  logic [IDX_W-1:0]   step_q, step_d;
  logic [CNT_W-1:0]   kept_q, kept_d;
  logic [SCORE_W-1:0] lowest_q, lowest_d;
  logic [STAMP_W-1:0] ctr_q, ctr_d;
  logic [KEEP_W-1:0]  keep_count_q;
  logic               use_mapq_q;
  logic [SCORE_W-1:0] score_q;
  logic [ID_BITS-1:0] id_q;

  logic                m_tvalid_q;
  logic                out_acc_q, out_idv_q, out_last_q;
  logic [OUT_ID_W-1:0] out_id_q;
  logic [SCORE_W-1:0]  out_score_q;
  logic [TOTAL_W-1:0]  out_total_q;

  logic                emit, e_acc, e_idv, e_last;
  logic [OUT_ID_W-1:0] e_id;
  logic [SCORE_W-1:0]  e_score;
  logic [TOTAL_W-1:0]  e_total;

  logic               in_fire, out_free, full;
  logic [MAPQ_W-1:0]  in_mapq;
  logic [MEDQ_W-1:0]  in_medq;
  logic [IN_ID_W-1:0] in_id;
  logic [SCORE_W-1:0] in_score;
  logic [KW-1:0]      keep_ext, keep_eff;

  logic               shift_en, wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [SCORE_W-1:0] cell_score [MAX_KEEP];
  logic [ID_BITS-1:0] cell_id    [MAX_KEEP];
  logic [STAMP_W-1:0] cell_stamp [MAX_KEEP];

  scan_ctl_t          scan_ctl;
  logic               scan_found, scan_dup;
  logic [IDX_W-1:0]   best_idx;
  logic [ID_BITS-1:0] best_id;
  logic [SCORE_W-1:0] best_score, second;

  assign in_mapq  = s_axis_tdata[7:0];
  assign in_medq  = s_axis_tdata[14:8];
  assign in_id    = s_axis_tdata[46:15];
  assign in_score = SCORE_W'(in_medq) + (use_mapq_q ? {1'b0, in_mapq, 2'b00} : '0);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = !m_tvalid_q | m_axis_tready;

  always_comb begin
    keep_ext = KW'(keep_count_q);
    if (keep_ext == '0) begin
      keep_eff = KW'(1);
    end else if (keep_ext > KW'(MAX_KEEP)) begin
      keep_eff = KW'(MAX_KEEP);
    end else begin
      keep_eff = keep_ext;
    end
    full = (KW'(kept_q) >= keep_eff);
  end

  // slot ring: cell i takes cell i+1, head is cell 0
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    tks_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk_i      (clk_i),
      .shift_en_i (shift_en),
      .wr_en_i    (wr_en && (wr_idx == IDX_W'(i))),
      .nb_score_i (cell_score[(i + 1) % MAX_KEEP]),
      .nb_id_i    (cell_id[(i + 1) % MAX_KEEP]),
      .nb_stamp_i (cell_stamp[(i + 1) % MAX_KEEP]),
      .wr_score_i (score_q),
      .wr_id_i    (id_q),
      .wr_stamp_i (ctr_q),
      .score_o    (cell_score[i]),
      .id_o       (cell_id[i]),
      .stamp_o    (cell_stamp[i])
    );
  end

  tks_scan #(.MAX_KEEP(MAX_KEEP), .ID_BITS(ID_BITS)) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .slot_i       (step_q),
    .score_i      (cell_score[0]),
    .id_i         (cell_id[0]),
    .stamp_i      (cell_stamp[0]),
    .lowest_i     (lowest_q),
    .ctr_i        (ctr_q),
    .found_o      (scan_found),
    .dup_o        (scan_dup),
    .best_idx_o   (best_idx),
    .best_id_o    (best_id),
    .best_score_o (best_score),
    .second_o     (second)
  );

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    kept_d   = kept_q;
    lowest_d = lowest_q;
    ctr_d    = ctr_q;
    shift_en = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = kept_q[IDX_W-1:0];
    scan_ctl = '0;
    emit     = 1'b0;
    e_acc    = 1'b0;
    e_idv    = 1'b0;
    e_id     = '0;
    e_score  = '0;
    e_total  = TOTAL_W'(kept_q);
    e_last   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (s_axis_tuser == OP_DRAIN) ? ST_DRAIN : ST_DECIDE;
          step_d  = '0;
        end
      end
      ST_DECIDE: begin
        if (!full) begin
          if (out_free) begin
            wr_en   = 1'b1;
            kept_d  = kept_q + CNT_W'(1);
            ctr_d   = ctr_q + STAMP_W'(1);
            if (score_q < lowest_q) begin
              lowest_d = score_q;
            end
            emit    = 1'b1;
            e_acc   = 1'b1;
            e_total = TOTAL_W'(kept_d);
            state_d = ST_IDLE;
          end
        end else if (score_q > lowest_q) begin
          state_d = ST_SCAN;
          step_d  = '0;
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        shift_en          = 1'b1;
        scan_ctl.en       = 1'b1;
        scan_ctl.first    = (step_q == '0);
        scan_ctl.in_range = (CNT_W'(step_q) < kept_q);
        step_d            = step_q + IDX_W'(1);
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = ST_REPLACE;
        end
      end
      ST_REPLACE: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (scan_found) begin
            wr_en   = 1'b1;
            wr_idx  = best_idx;
            ctr_d   = ctr_q + STAMP_W'(1);
            if (!scan_dup) begin
              lowest_d = (score_q < second) ? score_q : second;
            end
            e_acc   = 1'b1;
            e_idv   = 1'b1;
            e_id    = OUT_ID_W'(best_id);
            e_score = best_score;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit    = 1'b1;
          e_total = '0;
          if (kept_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            shift_en = 1'b1;
            e_idv    = 1'b1;
            e_id     = OUT_ID_W'(cell_id[0]);
            e_score  = cell_score[0];
            e_last   = (CNT_W'(step_q) == (kept_q - CNT_W'(1)));
            step_d   = step_q + IDX_W'(1);
            if (e_last) begin
              state_d = ST_IDLE;
            end
          end
          if (state_d == ST_IDLE) begin
            kept_d   = '0;
            lowest_d = TOP_SCORE;
            ctr_d    = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      kept_q       <= '0;
      lowest_q     <= TOP_SCORE;
      ctr_q        <= '0;
      keep_count_q <= KEEP_RESET;
      use_mapq_q   <= 1'b0;
      m_tvalid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      kept_q   <= kept_d;
      lowest_q <= lowest_d;
      ctr_q    <= ctr_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_KEEP_COUNT: keep_count_q <= cfg_wdata_i[KEEP_W-1:0];
          REG_USE_MAPQ:   use_mapq_q   <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (emit) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      score_q <= in_score;
      id_q    <= ID_BITS'(in_id);
    end
    if (emit) begin
      out_acc_q   <= e_acc;
      out_idv_q   <= e_idv;
      out_id_q    <= e_id;
      out_score_q <= e_score;
      out_total_q <= e_total;
      out_last_q  <= e_last;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = M_TDATA_W'({out_total_q, out_score_q, out_id_q});
  assign m_axis_tuser  = {out_idv_q, out_acc_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: verif/top_k_score_selector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_selector_unit_tb
// Drives offer and drain words into the selector and checks every output
// word against a cycle-free copy of the keep-best-reads store. A directed
// table covers the empty drain, the score extremes, ties at the lowest score,
// clamped keep counts and a keep count lowered below the store fill. Random
// words then run under three idle and stall mixes and several settings.
// ----------------------------------------------------------------------------
module top_k_score_selector_unit_tb;
  import tks_pkg::*;

  localparam int KEEP_MAX    = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic                accepted;
    logic                id_valid;
    logic [OUT_ID_W-1:0] id;
    logic [SCORE_W-1:0]  score;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } outcome_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // ROW_CFG rows: medq holds keep_count, mapq holds the use_mapq write data
  typedef struct packed {
    row_kind_e           kind;
    logic                op;
    logic [MAPQ_W-1:0]   mapq;
    logic [MEDQ_W-1:0]   medq;
    logic [IN_ID_W-1:0]  id;
    logic                fixed;
    outcome_t            want;
  } row_t;

  localparam outcome_t NO_WANT = '0;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // mapq, median_q, read_id
  logic                  s_axis_tuser = 1'b0;  // op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;  // out_id, out_score, kept_total
  logic [M_TUSER_W-1:0]  m_axis_tuser;  // accepted, id_valid
  logic                  m_axis_tlast;

  top_k_score_selector_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow store
  logic [SCORE_W-1:0]  kept_score [KEEP_MAX];
  logic [IN_ID_W-1:0]  kept_id    [KEEP_MAX];
  logic [STAMP_W-1:0]  kept_stamp [KEEP_MAX];
  int                  kept_n = 0;
  logic [SCORE_W-1:0]  low_score = TOP_SCORE;
  logic [STAMP_W-1:0]  stamp_ctr = '0;
  logic [KEEP_W-1:0]   keep_cfg = KEEP_RESET;
  logic                mapq_cfg = 1'b0;

  outcome_t outcome_q [$];
  row_t     dir_rows [$];
  outcome_t head;
  int       err_count = 0;
  int       cycle_count = 0;
  int       send_idle = 0;
  int       take_stall = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic rank_read(input logic op, input logic [MAPQ_W-1:0] mapq,
                           input logic [MEDQ_W-1:0] medq, input logic [IN_ID_W-1:0] id,
                           input logic fixed, input outcome_t want);
    outcome_t           w;
    outcome_t           loc [$];
    logic [SCORE_W-1:0] sc;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] best_age;
    int                 keep;
    int                 best;
    if (op == OP_DRAIN) begin
      if (kept_n == 0) begin
        w = '0;
        w.last = 1'b1;
        loc.push_back(w);
      end else begin
        for (int i = 0; i < kept_n; i++) begin
          w = '0;
          w.id_valid = 1'b1;
          w.id = kept_id[i];
          w.score = kept_score[i];
          w.last = (i == kept_n - 1);
          loc.push_back(w);
        end
      end
      kept_n = 0;
      low_score = TOP_SCORE;
      stamp_ctr = '0;
    end else begin
      keep = (keep_cfg == 0) ? 1 : ((keep_cfg > KEEP_MAX) ? KEEP_MAX : int'(keep_cfg));
      sc = {4'b0, medq} + (mapq_cfg ? {1'b0, mapq, 2'b00} : 11'd0);
      w = '0;
      w.last = 1'b1;
      if (kept_n < keep) begin
        kept_score[kept_n] = sc;
        kept_id[kept_n] = id;
        kept_stamp[kept_n] = stamp_ctr;
        stamp_ctr++;
        kept_n++;
        if (sc < low_score) low_score = sc;
        w.accepted = 1'b1;
      end else if (sc > low_score) begin
        best = -1;
        best_age = '0;
        for (int i = 0; i < kept_n; i++) begin
          age = stamp_ctr - kept_stamp[i];
          if (kept_score[i] == low_score && (best < 0 || age < best_age)) begin
            best = i;
            best_age = age;
          end
        end
        w.accepted = 1'b1;
        w.id_valid = 1'b1;
        w.id = kept_id[best];
        w.score = kept_score[best];
        kept_score[best] = sc;
        kept_id[best] = id;
        kept_stamp[best] = stamp_ctr;
        stamp_ctr++;
        low_score = TOP_SCORE;
        for (int i = 0; i < kept_n; i++)
          if (kept_score[i] < low_score) low_score = kept_score[i];
      end
      w.total = TOTAL_W'(kept_n);
      loc.push_back(w);
    end
    if (fixed) outcome_q.push_back(want);
    else foreach (loc[i]) outcome_q.push_back(loc[i]);
  endtask

  task automatic push_word(input logic op, input logic [MAPQ_W-1:0] mapq,
                           input logic [MEDQ_W-1:0] medq, input logic [IN_ID_W-1:0] id,
                           input logic fixed, input outcome_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, id, medq, mapq};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rank_read(op, mapq, medq, id, fixed, want);
  endtask

  task automatic drain_wait();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [KEEP_W-1:0] keep, input logic [CFG_DATA_W-1:0] flag);
    drain_wait();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_KEEP_COUNT;
    cfg_wdata_i <= keep;
    @(negedge clk_i);
    cfg_addr_i  <= REG_USE_MAPQ;
    cfg_wdata_i <= flag;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    keep_cfg = keep;
    mapq_cfg = flag[0];
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= take_stall);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (outcome_q.size() == 0) begin
        flag_mismatch("word with nothing pending", m_axis_tdata[31:0], 0);
      end else begin
        head = outcome_q.pop_front();
        if (m_axis_tuser[0] !== head.accepted)
          flag_mismatch("accepted", 32'(m_axis_tuser[0]), 32'(head.accepted));
        if (m_axis_tuser[1] !== head.id_valid)
          flag_mismatch("id_valid", 32'(m_axis_tuser[1]), 32'(head.id_valid));
        if (m_axis_tdata[31:0] !== head.id)
          flag_mismatch("out_id", m_axis_tdata[31:0], head.id);
        if (m_axis_tdata[42:32] !== head.score)
          flag_mismatch("out_score", 32'(m_axis_tdata[42:32]), 32'(head.score));
        if (m_axis_tdata[49:43] !== head.total)
          flag_mismatch("kept_total", 32'(m_axis_tdata[49:43]), 32'(head.total));
        if (m_axis_tlast !== head.last)
          flag_mismatch("last", 32'(m_axis_tlast), 32'(head.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("top_k_score_selector_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int             seg_keep  [6] = '{2, 64, 0, 5, 127, 0};
    int             seg_len   [6] = '{15, 70, 15, 15, 15, 20};
    int             seg_drain [6] = '{8, 0, 10, 8, 5, 8};
    int             idle_mix  [3] = '{37, 74, 0};
    int             stall_mix [3] = '{74, 37, 0};
    row_t           r;
    logic           op;
    logic [MEDQ_W-1:0] medq;
    logic [MAPQ_W-1:0] mapq;

    dir_rows.push_back('{ROW_WORD, OP_DRAIN, 8'd0, 7'd0, 32'd0, 1'b1,
                         '{1'b0, 1'b0, 32'd0, 11'd0, 7'd0, 1'b1}});
    dir_rows.push_back('{ROW_CFG, OP_OFFER, 8'd1, 7'd0, 32'd0, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd255, 7'd127, 32'hFFFF_FFFF, 1'b1,
                         '{1'b1, 1'b0, 32'd0, 11'd0, 7'd1, 1'b1}});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd0, 7'd0, 32'd0, 1'b1,
                         '{1'b0, 1'b0, 32'd0, 11'd0, 7'd1, 1'b1}});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd255, 7'd127, 32'd1, 1'b1,
                         '{1'b0, 1'b0, 32'd0, 11'd0, 7'd1, 1'b1}});
    dir_rows.push_back('{ROW_WORD, OP_DRAIN, 8'd0, 7'd0, 32'd0, 1'b1,
                         '{1'b0, 1'b1, 32'hFFFF_FFFF, 11'd1147, 7'd0, 1'b1}});
    dir_rows.push_back('{ROW_CFG, OP_OFFER, 8'd0, 7'd3, 32'd0, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd200, 7'd10, 32'h10, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd7, 7'd10, 32'h11, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd0, 7'd20, 32'h12, 1'b0, NO_WANT});
    // ties with the lowest score are turned away
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd0, 7'd10, 32'h13, 1'b0, NO_WANT});
    // evicts the newer of the two entries at the lowest score
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd0, 7'd11, 32'h14, 1'b0, NO_WANT});
    // keep count now below the fill
    dir_rows.push_back('{ROW_CFG, OP_OFFER, 8'd1, 7'd1, 32'd0, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd1, 7'd8, 32'h15, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd0, 7'd0, 32'h16, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_DRAIN, 8'd0, 7'd0, 32'd0, 1'b0, NO_WANT});
    // only bit 0 of the use_mapq data counts
    dir_rows.push_back('{ROW_CFG, OP_OFFER, 8'h7E, 7'd127, 32'd0, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'd255, 7'd0, 32'h17, 1'b1,
                         '{1'b1, 1'b0, 32'd0, 11'd0, 7'd1, 1'b1}});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'hAA, 7'h55, 32'h5555_AAAA, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_OFFER, 8'h55, 7'h2A, 32'hAAAA_5555, 1'b0, NO_WANT});
    dir_rows.push_back('{ROW_WORD, OP_DRAIN, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 1'b0, NO_WANT});

    send_idle  = idle_mix[0];
    take_stall = stall_mix[0];
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) set_config(r.medq, r.mapq[CFG_DATA_W-1:0]);
      else push_word(r.op, r.mapq, r.medq, r.id, r.fixed, r.want);
    end

    for (int s = 0; s < 6; s++) begin
      if (s == 5) seg_keep[s] = $urandom_range(8, 1);
      set_config(KEEP_W'(seg_keep[s]), {6'($urandom_range(63)), 1'($urandom_range(1))});
      send_idle  = idle_mix[s / 2];
      take_stall = stall_mix[s / 2];
      for (int i = 0; i < seg_len[s]; i++) begin
        if (i == seg_len[s] / 2) begin
          drain_wait();
          repeat (3) @(posedge clk_i);
        end
        op   = ($urandom_range(99) < seg_drain[s]) ? OP_DRAIN : OP_OFFER;
        mapq = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        medq = $urandom_range(1) ? 7'($urandom_range(13, 10)) : 7'($urandom_range(127));
        push_word(op, mapq, medq, $urandom, 1'b0, NO_WANT);
      end
      // full store of the widest keep count
      if (s == 1) push_word(OP_DRAIN, '0, '0, '0, 1'b0, NO_WANT);
    end

    drain_wait();
    repeat (2 * KEEP_MAX + 8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("top_k_score_selector_unit_tb: done, clean");
    end else begin
      $display("top_k_score_selector_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
